>>> design/fbc_pkg.sv
// fbc_pkg: shared types and constants for the frustum box classifier
// no dependencies; imported by fbc_front, fbc_back and the top level
`default_nettype none

package fbc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int NUM_AXES   = 3;
  localparam int COEF_W     = 16;
  localparam int PLANE_W    = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_COORD_W = 16;
  localparam int LEVEL_W    = 4;
  localparam int CLASS_W    = 2;
  localparam int D_SHIFT    = 14;
  localparam int QUEUE_DEPTH = 4;

  // bit offset of the offset term inside a plane register
  localparam int D_LSB = NUM_AXES * COEF_W;

  localparam logic [CLASS_W-1:0] CLS_OUTSIDE = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_PARTLY  = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_INSIDE  = 2'd2;

  // what the front end decides before the plane test
  typedef struct packed {
    logic                need_test;
    logic [CLASS_W-1:0]  cls;
    logic [LEVEL_W-1:0]  score;
  } fbc_meta_t;

  localparam int META_W = $bits(fbc_meta_t);

endpackage

`default_nettype wire

>>> design/fbc_front.sv
// fbc_front: input word intake and early classification by parent and level
// depends on fbc_pkg; feeds fbc_queue
`default_nettype none

module fbc_front #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [fbc_pkg::IN_COORD_W-1:0]    in_box_min_x,
  input  wire logic [fbc_pkg::IN_COORD_W-1:0]    in_box_max_x,
  input  wire logic [fbc_pkg::IN_COORD_W-1:0]    in_box_min_y,
  input  wire logic [fbc_pkg::IN_COORD_W-1:0]    in_box_max_y,
  input  wire logic [fbc_pkg::IN_COORD_W-1:0]    in_box_min_z,
  input  wire logic [fbc_pkg::IN_COORD_W-1:0]    in_box_max_z,
  input  wire logic [fbc_pkg::LEVEL_W-1:0]       in_tree_level,
  input  wire logic [fbc_pkg::CLASS_W-1:0]       in_parent_class,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output fbc_pkg::fbc_meta_t                     q_meta,
  output logic [2*fbc_pkg::NUM_AXES*COORD_WIDTH-1:0] q_coords
);
  import fbc_pkg::*;

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

  // only the low coordinate bits matter; the back end treats them as signed
  assign q_coords = {in_box_max_z[COORD_WIDTH-1:0], in_box_min_z[COORD_WIDTH-1:0],
                     in_box_max_y[COORD_WIDTH-1:0], in_box_min_y[COORD_WIDTH-1:0],
                     in_box_max_x[COORD_WIDTH-1:0], in_box_min_x[COORD_WIDTH-1:0]};

  always_comb begin
    q_meta.need_test = 1'b0;
    q_meta.cls       = CLS_PARTLY;
    q_meta.score     = in_tree_level;
    if (in_parent_class == CLS_OUTSIDE) begin
      q_meta.cls   = CLS_OUTSIDE;
      q_meta.score = '0;
    end else if (in_tree_level == '0) begin
      q_meta.cls   = CLS_PARTLY;
      q_meta.score = '0;
    end else if (in_parent_class == CLS_INSIDE) begin
      q_meta.cls = CLS_INSIDE;
    end else begin
      // partly, or the unused code, goes through the plane test
      q_meta.need_test = 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> design/fbc_queue.sv
// fbc_queue: small first-in first-out buffer between front and back end
// depends on nothing; it does not use the package
`default_nettype none

module fbc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  full,
  output logic                  not_empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign rdata     = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/fbc_back.sv
// fbc_back: plane registers and the pipelined p-vertex / n-vertex test
// depends on fbc_pkg; drains fbc_queue and drives the result register
`default_nettype none

module fbc_back #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [fbc_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  wire logic [fbc_pkg::PLANE_W-1:0]           cfg_wdata,
  input  wire logic                                  q_not_empty,
  input  wire fbc_pkg::fbc_meta_t                    q_meta,
  input  wire logic [2*fbc_pkg::NUM_AXES*COORD_WIDTH-1:0] q_coords,
  output logic                                       q_pop,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [fbc_pkg::CLASS_W-1:0]                out_node_class,
  output logic [fbc_pkg::LEVEL_W-1:0]                out_node_score
);
  import fbc_pkg::*;

  localparam int PROD_W = COEF_W + COORD_WIDTH;
  localparam int SUM_W  = PROD_W + 2;

  logic [PLANE_W-1:0] plane_r [NUM_PLANES];

  logic signed [PROD_W-1:0] far_prod  [NUM_PLANES][NUM_AXES];
  logic signed [PROD_W-1:0] near_prod [NUM_PLANES][NUM_AXES];
  logic signed [PROD_W-1:0] far_prod_r  [NUM_PLANES][NUM_AXES];
  logic signed [PROD_W-1:0] near_prod_r [NUM_PLANES][NUM_AXES];

  logic signed [SUM_W-1:0] far_sum  [NUM_PLANES];
  logic signed [SUM_W-1:0] near_sum [NUM_PLANES];
  logic [NUM_PLANES-1:0]   far_neg, near_neg;
  logic [NUM_PLANES-1:0]   far_neg_r, near_neg_r;

  fbc_meta_t s1_meta_r, s2_meta_r;
  logic      s1_valid_r, s2_valid_r, out_valid_r;
  logic [CLASS_W-1:0] out_class_r, class_nxt;
  logic [LEVEL_W-1:0] out_score_r;
  logic      pipe_en;

  // whole pipeline moves whenever the result register is free or being taken
  assign pipe_en = ~out_valid_r | ~out_stall;
  assign q_pop   = pipe_en & q_not_empty;

  assign out_valid      = out_valid_r;
  assign out_node_class = out_class_r;
  assign out_node_score = out_score_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        plane_r[p] <= '0;
      end
    end else if (cfg_we && (cfg_idx < CFG_IDX_W'(NUM_PLANES))) begin
      plane_r[cfg_idx] <= cfg_wdata;
    end
  end

  // stage 1: pick far and near corner per axis, multiply by the normal
  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        logic signed [COEF_W-1:0]      n;
        logic signed [COORD_WIDTH-1:0] lo, hi, far_c, near_c;
        n      = signed'(plane_r[p][a*COEF_W +: COEF_W]);
        lo     = signed'(q_coords[(2*a)*COORD_WIDTH +: COORD_WIDTH]);
        hi     = signed'(q_coords[(2*a+1)*COORD_WIDTH +: COORD_WIDTH]);
        far_c  = n[COEF_W-1] ? lo : hi;
        near_c = n[COEF_W-1] ? hi : lo;
        far_prod[p][a]  = PROD_W'(n) * PROD_W'(far_c);
        near_prod[p][a] = PROD_W'(n) * PROD_W'(near_c);
      end
    end
  end

  // stage 2: add the shifted offset and take the sign
  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      logic signed [SUM_W-1:0] d_term;
      d_term = SUM_W'(signed'(plane_r[p][D_LSB +: COEF_W])) <<< D_SHIFT;
      far_sum[p]  = d_term + SUM_W'(far_prod_r[p][0]) + SUM_W'(far_prod_r[p][1])
                  + SUM_W'(far_prod_r[p][2]);
      near_sum[p] = d_term + SUM_W'(near_prod_r[p][0]) + SUM_W'(near_prod_r[p][1])
                  + SUM_W'(near_prod_r[p][2]);
      far_neg[p]  = far_sum[p][SUM_W-1];
      near_neg[p] = near_sum[p][SUM_W-1];
    end
  end

  // stage 3: fold the plane flags into a class, or keep the front-end class when no test is needed
  always_comb begin
    class_nxt = s2_meta_r.cls;
    if (s2_meta_r.need_test) begin
      if (|far_neg_r) begin
        class_nxt = CLS_OUTSIDE;
      end else if (|near_neg_r) begin
        class_nxt = CLS_PARTLY;
      end else begin
        class_nxt = CLS_INSIDE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      far_prod_r  <= far_prod;
      near_prod_r <= near_prod;
      s1_meta_r   <= q_meta;
      far_neg_r   <= far_neg;
      near_neg_r  <= near_neg;
      s2_meta_r   <= s1_meta_r;
      out_class_r <= class_nxt;
      out_score_r <= s2_meta_r.score;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r  <= q_pop;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

endmodule

`default_nettype wire

>>> design/frustum_box_classify.sv
// frustum_box_classify: top level of the frustum box classifier
// depends on fbc_pkg, fbc_front, fbc_queue and fbc_back
//
//   port group   direction  handshake            payload
//   in_*         input      in_valid / in_stall   six box bounds, level, parent class
//   out_*        output     out_valid / out_stall node class, node score
//   cfg_*        input      cfg_valid / cfg_ready plane register index and data
//
// one box per cycle sustained while out_stall is low; a word accepted at the input passes the
// queue read with the multiply, the plane-sum stage and the class register on its way to out_valid.
// the four-entry queue lets the front keep taking words while the result stalls;
// in_stall rises only when the queue is full.
// reset (rst_n low, synchronous) empties queue and pipeline and zeroes all planes.
// cfg_ready is always high; planes should be written only while the block is idle.
`default_nettype none

module frustum_box_classify #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [fbc_pkg::IN_COORD_W-1:0]    in_box_min_x,
  input  wire logic [fbc_pkg::IN_COORD_W-1:0]    in_box_max_x,
  input  wire logic [fbc_pkg::IN_COORD_W-1:0]    in_box_min_y,
  input  wire logic [fbc_pkg::IN_COORD_W-1:0]    in_box_max_y,
  input  wire logic [fbc_pkg::IN_COORD_W-1:0]    in_box_min_z,
  input  wire logic [fbc_pkg::IN_COORD_W-1:0]    in_box_max_z,
  input  wire logic [fbc_pkg::LEVEL_W-1:0]       in_tree_level,
  input  wire logic [fbc_pkg::CLASS_W-1:0]       in_parent_class,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [fbc_pkg::CLASS_W-1:0]            out_node_class,
  output logic [fbc_pkg::LEVEL_W-1:0]            out_node_score,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [fbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fbc_pkg::PLANE_W-1:0]       cfg_data
);
  import fbc_pkg::*;

  localparam int COORDS_W = 2 * NUM_AXES * COORD_WIDTH;
  localparam int ENTRY_W  = META_W + COORDS_W;

  logic                q_push, q_pop, q_full, q_not_empty;
  fbc_meta_t           push_meta, pop_meta;
  logic [COORDS_W-1:0] push_coords, pop_coords;
  logic [ENTRY_W-1:0]  pop_entry;

  assign cfg_ready  = 1'b1;
  assign pop_meta   = pop_entry[ENTRY_W-1 -: META_W];
  assign pop_coords = pop_entry[COORDS_W-1:0];

  fbc_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_box_min_x   (in_box_min_x),
    .in_box_max_x   (in_box_max_x),
    .in_box_min_y   (in_box_min_y),
    .in_box_max_y   (in_box_max_y),
    .in_box_min_z   (in_box_min_z),
    .in_box_max_z   (in_box_max_z),
    .in_tree_level  (in_tree_level),
    .in_parent_class(in_parent_class),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_meta         (push_meta),
    .q_coords       (push_coords)
  );

  fbc_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    ({push_meta, push_coords}),
    .pop      (q_pop),
    .rdata    (pop_entry),
    .full     (q_full),
    .not_empty(q_not_empty)
  );

  fbc_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_idx       (cfg_index),
    .cfg_wdata     (cfg_data),
    .q_not_empty   (q_not_empty),
    .q_meta        (pop_meta),
    .q_coords      (pop_coords),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_node_class(out_node_class),
    .out_node_score(out_node_score)
  );

endmodule

`default_nettype wire
